FILE: rtl/gda_pkg.sv
// ============================================================================
// Gregorian date adder package
// Field widths, month codes and the constants used by the year reduction.
// ============================================================================
`default_nettype none

package gda_pkg;

   // Field widths of one request and one response.
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DAYS_W  = 16;

   // Width of the shared compare and subtract unit.
   localparam int UNIT_W = YEAR_W;

   // Widths of the year remainders kept beside the year.
   localparam int R400_W = 9;
   localparam int R100_W = 7;

   // Month codes.
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // Month lengths.
   localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
   localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
   localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
   localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
   localparam logic [DAY_W-1:0] LEN_NONE  = 5'd0;

   // Year reduction: the first six steps leave the year modulo 400,
   // the last two leave it modulo 100.
   localparam int RED_STEPS = 8;
   localparam int RED_CNT_W = 3;
   localparam int RED_LAST_400 = 5;
   typedef logic [UNIT_W-1:0] red_table_type [RED_STEPS];
   localparam red_table_type RED_SUB = '{
      14'd12800, 14'd6400, 14'd3200, 14'd1600,
      14'd800,   14'd400,  14'd200,  14'd100
   };

   // Limits for the incremental year remainders.
   localparam logic [R400_W-1:0] R400_LAST = 9'd399;
   localparam logic [R100_W-1:0] R100_LAST = 7'd99;

   // Result of one pass through the shared unit.
   typedef struct packed {
      logic              ge;
      logic [UNIT_W-1:0] diff;
   } unit_res_type;

endpackage

`default_nettype wire

FILE: rtl/gda_sub_unit.sv
// ============================================================================
// Gregorian date adder shared compare and subtract unit
// Computes a - b and whether a is at least b; reused by the reduce, check and step phases.
// ============================================================================
`default_nettype none

module gda_sub_unit
   import gda_pkg::*;
(
   input  wire logic [UNIT_W-1:0] op_a,
   input  wire logic [UNIT_W-1:0] op_b,
   output unit_res_type           res
);

   logic [UNIT_W:0] wide_diff;

   // One subtract with borrow; no borrow means a is at least b.
   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign res.ge    = ~wide_diff[UNIT_W];
   assign res.diff  = wide_diff[UNIT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/gda_month_len.sv
// ============================================================================
// Gregorian date adder month length table
// Gives the number of days in a month, zero for a month code outside 1..12.
// ============================================================================
`default_nettype none

module gda_month_len
   import gda_pkg::*;
(
   input  wire logic [MONTH_W-1:0] month,
   input  wire logic               leap,
   output logic      [DAY_W-1:0]   len
);

   // February follows the leap flag; other months are fixed.
   always_comb begin
      case (month)
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: begin
            len = LEN_LONG;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            len = LEN_SHORT;
         end
         MONTH_FEB: begin
            len = leap ? LEN_LEAP : LEN_FEB;
         end
         default: begin
            len = LEN_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_add_days.sv
// ============================================================================
// Gregorian date adder
// Checks a starting date and adds a number of days to it, one day per cycle.
// ============================================================================
//
//  Channel  Direction  Payload (lowest bit first)
//  req_     in         tdata: day_in, month_in, year_in, days_to_add
//  rsp_     out        tdata: day_out, month_out, year_out; tuser: date_valid
//
// An item is loaded, its year reduced modulo 400 and 100 in eight steps in
// the shared subtract unit, and the date checked; a valid date then gets
// one day added per step until the count runs out, and the result is
// handed to the output register. A result still waiting there holds the
// sequencer in its done state. The output register holds a finished
// result while the next item is taken.
// Reset is synchronous and clears the sequencer and the output valid.
//
`default_nettype none

module gregorian_date_add_days
   import gda_pkg::*;
#(
   parameter int MAX_ADD_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request: day_in[4:0], month_in[8:5], year_in[22:9], days_to_add[38:23], zero[39]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // Response: day_out[4:0], month_out[8:5], year_out[22:9], zero[23]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   // Response: date_valid[0]
   output logic [0:0]       rsp_tuser
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam int DAY_LO   = 0;
   localparam int MONTH_LO = DAY_LO + DAY_W;
   localparam int YEAR_LO  = MONTH_LO + MONTH_W;
   localparam int DAYS_LO  = YEAR_LO + YEAR_W;

   logic [2:0]              state_ff, state_in;
   logic [RED_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DAY_W-1:0]        day_ff, day_in;
   logic [MONTH_W-1:0]      month_ff, month_in;
   logic [YEAR_W-1:0]       year_ff, year_in;
   logic [MAX_ADD_BITS-1:0] left_ff, left_in;
   logic [UNIT_W-1:0]       red_ff, red_in;
   logic [R400_W-1:0]       r400_ff, r400_in;
   logic [R100_W-1:0]       r100_ff, r100_in;
   logic                    valid_ff, valid_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [YEAR_LO+YEAR_W-1:0] rsp_data_ff, rsp_data_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic [DAYS_W-1:0]       days_field;
   logic [MAX_ADD_BITS-1:0] left_load;
   logic [UNIT_W-1:0]       op_a, op_b;
   unit_res_type            unit_res;
   logic                    leap;
   logic [DAY_W-1:0]        cur_len;
   logic                    out_free;

   // Day count taken from the request, cut or widened to the counter width.
   assign days_field = req_tdata[DAYS_LO +: DAYS_W];
   generate
      if (MAX_ADD_BITS <= DAYS_W) begin : g_cut
         assign left_load = days_field[MAX_ADD_BITS-1:0];
      end else begin : g_widen
         assign left_load = {{(MAX_ADD_BITS-DAYS_W){1'b0}}, days_field};
      end
   endgenerate

   // Leap rule from the year's low bits and its remainders by 100 and 400.
   assign leap = ((year_ff[1:0] == 2'b00) && (r100_ff != '0)) || (r400_ff == '0);

   gda_month_len u_month_len (
      .month (month_ff),
      .leap  (leap),
      .len   (cur_len)
   );

   // Operand selection for the shared unit.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_REDUCE: begin
            op_a = red_ff;
            op_b = RED_SUB[cnt_ff];
         end
         ST_CHECK: begin
            op_a = {{(UNIT_W-DAY_W){1'b0}}, cur_len};
            op_b = {{(UNIT_W-DAY_W){1'b0}}, day_ff};
         end
         ST_STEP: begin
            op_a = {{(UNIT_W-DAY_W){1'b0}}, day_ff};
            op_b = {{(UNIT_W-DAY_W){1'b0}}, cur_len};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   gda_sub_unit u_sub_unit (
      .op_a (op_a),
      .op_b (op_b),
      .res  (unit_res)
   );

   assign out_free = ~rsp_tvalid_ff | rsp_tready;

   // Sequencer and date registers.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      day_in        = day_ff;
      month_in      = month_ff;
      year_in       = year_ff;
      left_in       = left_ff;
      red_in        = red_ff;
      r400_in       = r400_ff;
      r100_in       = r100_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_flag_in   = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               day_in   = req_tdata[DAY_LO +: DAY_W];
               month_in = req_tdata[MONTH_LO +: MONTH_W];
               year_in  = req_tdata[YEAR_LO +: YEAR_W];
               red_in   = req_tdata[YEAR_LO +: YEAR_W];
               left_in  = left_load;
               cnt_in   = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // Restoring reduction: keep the difference when it does not borrow.
            if (unit_res.ge) begin
               red_in = unit_res.diff;
            end
            if (cnt_ff == RED_CNT_W'(RED_LAST_400)) begin
               r400_in = red_in[R400_W-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == RED_CNT_W'(RED_STEPS - 1)) begin
               r100_in  = red_in[R100_W-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // A valid date has a day in 1..length and a known month.
            valid_in = unit_res.ge && (day_ff != '0) && (cur_len != LEN_NONE);
            state_in = valid_in ? ST_STEP : ST_DONE;
         end
         ST_STEP: begin
            if (left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               left_in = left_ff - 1'b1;
               if (!unit_res.ge) begin
                  day_in = day_ff + 1'b1;
               end else begin
                  day_in = DAY_W'(1);
                  if (month_ff == MONTH_DEC) begin
                     month_in = MONTH_JAN;
                     year_in  = year_ff + 1'b1;
                     // Remainders follow the year, and restart when it wraps.
                     if (year_ff == '1) begin
                        r400_in = '0;
                        r100_in = '0;
                     end else begin
                        r400_in = (r400_ff == R400_LAST) ? '0 : r400_ff + 1'b1;
                        r100_in = (r100_ff == R100_LAST) ? '0 : r100_ff + 1'b1;
                     end
                  end else begin
                     month_in = month_ff + 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            // Hand over once the output register is free.
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {year_ff, month_ff, day_ff};
               rsp_flag_in   = valid_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      left_ff     <= left_in;
      red_ff      <= red_in;
      r400_ff     <= r400_in;
      r100_ff     <= r100_in;
      valid_ff    <= valid_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = {1'b0, rsp_data_ff};
   assign rsp_tuser[0] = rsp_flag_ff;

endmodule

`default_nettype wire
